[hdl/voxel_visible_face_extract_defines.svh]
// Assertion macros shared by the voxel face extractor.
`ifndef VOXEL_VISIBLE_FACE_EXTRACT_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_EXTRACT_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define VVFE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vvfe assertion failed");
// Check a property on every clock edge, reset included.
`define VVFE_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("vvfe assertion failed");
`else
`define VVFE_ASSERT(label, clk, rst, prop)
`define VVFE_ASSERT_RST(label, clk, prop)
`endif
`endif

[hdl/vvfe_pkg.sv]
`timescale 1ns / 1ps
package vvfe_pkg;

   // Grid geometry and stored type width
   localparam int SIZE_XZ   = 16;
   localparam int SIZE_Y    = 256;
   localparam int TYPE_BITS = 8;

   // Field widths of the beats
   localparam int CMD_W     = 2;
   localparam int X_W       = 4;
   localparam int Y_W       = 8;
   localparam int Z_W       = 4;
   localparam int TYPE_IN_W = 8;
   localparam int DIR_W     = 3;
   localparam int VC_W      = 21;

   localparam int GRID_CELLS = SIZE_XZ * SIZE_XZ * SIZE_Y;
   localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int DIR_COUNT  = 6;
   localparam int RD_W       = 3;

   // Commands
   localparam logic [CMD_W-1:0] CMD_BEGIN = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_WRITE = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_MESH  = CMD_W'(2);

   // Read slots of one mesh pass: centre, then neighbors in face order
   localparam logic [RD_W-1:0] RD_CENTRE = RD_W'(0);
   localparam logic [RD_W-1:0] RD_PX     = RD_W'(1);
   localparam logic [RD_W-1:0] RD_NX     = RD_W'(2);
   localparam logic [RD_W-1:0] RD_PY     = RD_W'(3);
   localparam logic [RD_W-1:0] RD_NY     = RD_W'(4);
   localparam logic [RD_W-1:0] RD_PZ     = RD_W'(5);
   localparam logic [RD_W-1:0] RD_LAST   = RD_W'(6);

   localparam logic [VC_W-1:0] VC_STEP = VC_W'(4);

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [X_W-1:0]       block_x;
      logic [Y_W-1:0]       block_y;
      logic [Z_W-1:0]       block_z;
      logic [TYPE_IN_W-1:0] block_type;
   } req_type;

   typedef struct packed {
      logic [X_W-1:0]   face_x;
      logic [Y_W-1:0]   face_y;
      logic [Z_W-1:0]   face_z;
      logic [DIR_W-1:0] face_dir;
      logic [VC_W-1:0]  first_vertex;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [TYPE_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
   } store_req_type;

   // Linear cell address, x fastest, then y, then z
   function automatic logic [ADDR_W-1:0] cell_addr(int x, int y, int z);
      int a;
      a = x + y * SIZE_XZ + z * (SIZE_XZ * SIZE_Y);
      return ADDR_W'(a);
   endfunction

endpackage

[hdl/vvfe_store.sv]
`timescale 1ns / 1ps
module vvfe_store import vvfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  store_req_type        st_req,
   output logic [TYPE_BITS-1:0] rd_data,
   output logic                 clr_busy
);

   logic [TYPE_BITS-1:0] mem [GRID_CELLS];

   logic                 clr_ff, clr_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [TYPE_BITS-1:0] rd_data_ff;
   logic                 we;
   logic [ADDR_W-1:0]    wa;
   logic [TYPE_BITS-1:0] wd;

   // Sweep every cell to air after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(GRID_CELLS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // Give the sweep the write port while it runs
   always_comb begin
      we = clr_ff || st_req.wr_en;
      wa = clr_ff ? clr_addr_ff : st_req.wr_addr;
      wd = clr_ff ? '0 : st_req.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (st_req.rd_en) begin
         rd_data_ff <= mem[st_req.rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_ff;

endmodule

[hdl/vvfe_ctrl.sv]
`timescale 1ns / 1ps
module vvfe_ctrl import vvfe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 clr_busy,
   output store_req_type        st_req,
   input  logic [TYPE_BITS-1:0] st_rd_data
);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_DRAIN, S_EMIT} state_type;

   // Signed neighbor coordinates reach one below zero and one past the field
   localparam int XS_W   = X_W + 2;
   localparam int YS_W   = Y_W + 2;
   localparam int ZS_W   = Z_W + 2;
   localparam int TW_EXT = (TYPE_BITS > TYPE_IN_W) ? TYPE_BITS : TYPE_IN_W;
   localparam logic signed [XS_W-1:0] X_ONE = XS_W'(1);
   localparam logic signed [YS_W-1:0] Y_ONE = YS_W'(1);
   localparam logic signed [ZS_W-1:0] Z_ONE = ZS_W'(1);

   function automatic logic in_grid(logic signed [XS_W-1:0] x,
                                    logic signed [YS_W-1:0] y,
                                    logic signed [ZS_W-1:0] z);
      return (x >= 0) && (x < SIZE_XZ) && (y >= 0) && (y < SIZE_Y) &&
             (z >= 0) && (z < SIZE_XZ);
   endfunction

   state_type              state_ff, state_in;
   logic [X_W-1:0]         cx_ff, cx_in;
   logic [Y_W-1:0]         cy_ff, cy_in;
   logic [Z_W-1:0]         cz_ff, cz_in;
   logic [RD_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [RD_W-1:0]        rd_tag_ff, rd_tag_in;
   logic                   rd_ok_ff, rd_ok_in;
   logic                   solid_ff, solid_in;
   logic [DIR_COUNT-1:0]   air_ff, air_in;
   logic [VC_W-1:0]        vc_ff, vc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   ret_air;
   logic signed [XS_W-1:0] sx, nx, wx;
   logic signed [YS_W-1:0] sy, ny, wy;
   logic signed [ZS_W-1:0] sz, nz, wz;
   logic                   n_ok;
   logic [TW_EXT-1:0]      type_ext;
   logic [DIR_W-1:0]       sel;
   logic [DIR_COUNT-1:0]   air_rest;

   // Form the coordinates of the cell read in this slot
   always_comb begin
      sx = XS_W'(cx_ff);
      sy = YS_W'(cy_ff);
      sz = ZS_W'(cz_ff);
      nx = sx;
      ny = sy;
      nz = sz;
      case (rd_idx_ff)
         RD_PX:   nx = sx + X_ONE;
         RD_NX:   nx = sx - X_ONE;
         RD_PY:   ny = sy + Y_ONE;
         RD_NY:   ny = sy - Y_ONE;
         RD_PZ:   nz = sz + Z_ONE;
         RD_LAST: nz = sz - Z_ONE;
         default: ;
      endcase
      n_ok = in_grid(nx, ny, nz);
   end

   // Pick the lowest pending face
   always_comb begin
      sel = '0;
      for (int i = DIR_COUNT - 1; i >= 0; i--) begin
         if (air_ff[i]) begin
            sel = DIR_W'(i);
         end
      end
      air_rest      = air_ff;
      air_rest[sel] = 1'b0;
   end

   assign req_stall = (state_ff != S_IDLE) || clr_busy;
   assign accept    = req_valid && !req_stall;
   assign ret_air   = !rd_ok_ff || (st_rd_data == '0);

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      rd_tag_in    = rd_idx_ff;
      rd_ok_in     = n_ok;
      solid_in     = solid_ff;
      air_in       = air_ff;
      vc_in        = vc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // Write beats go straight to the store at acceptance
      wx       = XS_W'(req_data.block_x);
      wy       = YS_W'(req_data.block_y);
      wz       = ZS_W'(req_data.block_z);
      type_ext = TW_EXT'(req_data.block_type);
      st_req.wr_en   = accept && (req_data.cmd == CMD_WRITE) && in_grid(wx, wy, wz);
      st_req.wr_addr = cell_addr(int'(wx), int'(wy), int'(wz));
      st_req.wr_data = type_ext[TYPE_BITS-1:0];
      st_req.rd_en   = 1'b0;
      st_req.rd_addr = cell_addr(int'(nx), int'(ny), int'(nz));

      // Fold the returned read into solid and air flags
      if (rd_pend_ff) begin
         if (rd_tag_ff == RD_CENTRE) begin
            solid_in = !ret_air;
         end else begin
            air_in[DIR_W'(rd_tag_ff - 1'b1)] = ret_air;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cx_in = req_data.block_x;
               cy_in = req_data.block_y;
               cz_in = req_data.block_z;
               if (req_data.cmd == CMD_BEGIN) begin
                  vc_in = '0;
               end
               if (req_data.cmd == CMD_MESH) begin
                  state_in  = S_READ;
                  rd_idx_in = RD_CENTRE;
                  solid_in  = 1'b0;
                  air_in    = '0;
               end
            end
         end
         S_READ: begin
            st_req.rd_en = 1'b1;
            rd_pend_in   = 1'b1;
            if (rd_idx_ff == RD_LAST) begin
               state_in = S_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = (solid_in && (air_in != '0)) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            // Load the next face once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.face_x        = cx_ff;
               rsp_data_in.face_y        = cy_ff;
               rsp_data_in.face_z        = cz_ff;
               rsp_data_in.face_dir      = sel;
               rsp_data_in.first_vertex  = vc_ff;
               rsp_data_in.last          = (air_rest == '0);
               vc_in                     = vc_ff + VC_STEP;
               air_in                    = air_rest;
               if (air_rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         vc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      rd_idx_ff   <= rd_idx_in;
      rd_tag_ff   <= rd_tag_in;
      rd_ok_ff    <= rd_ok_in;
      solid_ff    <= solid_in;
      air_ff      <= air_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/voxel_visible_face_extract.sv]
// Begin-mesh and write beats are taken in the idle state. A mesh beat reads the centre and six
// neighbors through the single store read port, waits for the last read to return, then emits faces.
// Faces follow one a cycle while rsp_stall is low.
// Reset is synchronous, active high; it zeroes the vertex counter and starts a
// clearing pass over all GRID_CELLS (65536) cells during which req_stall stays high.
`timescale 1ns / 1ps
`include "voxel_visible_face_extract_defines.svh"
module voxel_visible_face_extract import vvfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   store_req_type        st_req;
   logic [TYPE_BITS-1:0] st_rd_data;
   logic                 clr_busy;

   vvfe_store u_store (
      .clock    (clock),
      .reset    (reset),
      .st_req   (st_req),
      .rd_data  (st_rd_data),
      .clr_busy (clr_busy)
   );

   vvfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .clr_busy   (clr_busy),
      .st_req     (st_req),
      .st_rd_data (st_rd_data)
   );

   `VVFE_ASSERT_RST(a_reset_starts_clear, clock, reset |=> clr_busy)
   `VVFE_ASSERT(a_no_beat_in_clear, clock, reset, ((req_valid && !req_stall) || rsp_valid) |-> !clr_busy)
   `VVFE_ASSERT(a_rw_exclusive, clock, reset, st_req.wr_en |-> !st_req.rd_en)
   `VVFE_ASSERT(a_vertex_aligned, clock, reset, rsp_valid |-> (rsp_data.first_vertex[1:0] == 2'b00))

endmodule
